@@ hdl/chc_pkg.sv @@
// Shared types and codes for the canonical Huffman code table engine.
// Depends on nothing; imported by canonical_huffman_code_table.
package chc_pkg;

    localparam int DEF_MAX_CODE_LENGTH = 16;
    localparam int DEF_SYMBOL_SLOTS    = 256;

    localparam int MODE_W   = 2;
    localparam int LEN_W    = 5;
    localparam int CNT_W    = 8;
    localparam int SYM_W    = 8;
    localparam int CODE_W   = 16;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 9;
    localparam int NEXT_W   = 17;

    localparam int TOTAL_MAX = 511;

    typedef logic [MODE_W-1:0]   t_mode;
    typedef logic [LEN_W-1:0]    t_len;
    typedef logic [CNT_W-1:0]    t_count;
    typedef logic [SYM_W-1:0]    t_symbol;
    typedef logic [CODE_W-1:0]   t_code;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_mode MODE_COUNT  = 2'd0;
    localparam t_mode MODE_SYMBOL = 2'd1;
    localparam t_mode MODE_LOOKUP = 2'd2;
    localparam t_mode MODE_CLEAR  = 2'd3;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_NO_FREE  = 2'd1;
    localparam t_status ST_NOT_FND  = 2'd2;
    localparam t_status ST_SURPLUS  = 2'd3;

endpackage

@@ hdl/canonical_huffman_code_table.sv @@
// Canonical Huffman code table engine: length counts, code assignment, lookup.
// Depends on chc_pkg (types, mode and status codes, defaults).
//
// One request at a time. Clear, surplus symbol and out-of-range count go straight to S_EMIT;
// count load passes S_CNT and lookup S_LOOK first, symbol load passes a read and a check state per code
// length passed (one length-count read each). The input stalls until the sequencer is back in idle.
// Reset (synchronous, active low) and a clear request empty both stores at once
// through per-entry valid flops; no clearing sweep, a clear only passes S_EMIT like any request.
module canonical_huffman_code_table #(
    parameter int MAX_CODE_LENGTH = chc_pkg::DEF_MAX_CODE_LENGTH,
    parameter int SYMBOL_SLOTS    = chc_pkg::DEF_SYMBOL_SLOTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  chc_pkg::t_mode    i_mode,
    input  chc_pkg::t_len     i_length_index,
    input  chc_pkg::t_count   i_count,
    input  chc_pkg::t_symbol  i_symbol,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output chc_pkg::t_code    o_code,
    output chc_pkg::t_len     o_code_length,
    output chc_pkg::t_status  o_status
);
    import chc_pkg::*;

    localparam int LC_AW   = $clog2(MAX_CODE_LENGTH);
    localparam int SLOT_AW = $clog2(SYMBOL_SLOTS);
    localparam int SUM_W   = $clog2(MAX_CODE_LENGTH * 255 + 1);
    localparam int ENTRY_W = LEN_W + CODE_W;

    // sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CNT     = 3'd1;
    localparam logic [2:0] S_LOOK    = 3'd2;
    localparam logic [2:0] S_ADV_RD  = 3'd3;
    localparam logic [2:0] S_ADV_CHK = 3'd4;
    localparam logic [2:0] S_EMIT    = 3'd5;

    // memories: per-length symbol counts, per-symbol {length, code}
    logic [CNT_W-1:0]   r_lc_mem [MAX_CODE_LENGTH];
    logic [ENTRY_W-1:0] r_st_mem [SYMBOL_SLOTS];
    logic [CNT_W-1:0]   r_lc_rdata;
    logic [ENTRY_W-1:0] r_st_rdata;

    // valid flops for both stores, cleared at once by reset or clear
    logic [MAX_CODE_LENGTH-1:0] r_lc_valid, n_lc_valid;
    logic [SYMBOL_SLOTS-1:0]    r_st_valid, n_st_valid;

    // control state
    logic [2:0]          r_state, n_state;
    logic [LEN_W-1:0]    r_cur_len, n_cur_len;
    logic [CNT_W-1:0]    r_placed_len, n_placed_len;
    logic [NEXT_W-1:0]   r_next_code, n_next_code;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [TOTAL_W-1:0]  r_placed_total, n_placed_total;
    logic                r_out_valid, n_out_valid;

    // captured request and pending result (payload, no reset)
    logic [LEN_W-1:0]    r_li, n_li;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [SYM_W-1:0]    r_sym, n_sym;
    logic [CODE_W-1:0]   r_res_code, n_res_code;
    logic [LEN_W-1:0]    r_res_len, n_res_len;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [CODE_W-1:0]   r_out_code, n_out_code;
    logic [LEN_W-1:0]    r_out_len, n_out_len;
    logic [STATUS_W-1:0] r_out_status, n_out_status;

    // memory port controls
    logic               lc_re, lc_we;
    logic [LC_AW-1:0]   lc_raddr, lc_waddr;
    logic               st_re, st_we;
    logic [SLOT_AW-1:0] st_raddr, st_waddr;
    logic [ENTRY_W-1:0] st_wdata;

    // helpers
    logic               w_in_acc;
    logic [LEN_W-1:0]   w_in_li_m1, w_li_m1, w_cl_m1;
    logic               w_in_li_ok, w_cl_ok, w_sym_ok, w_overfull;
    logic [TOTAL_W-1:0] w_total;
    logic [CNT_W-1:0]   w_old_cnt, w_cl_cnt;

    assign o_in_stall    = (r_state != S_IDLE);
    assign w_in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid   = r_out_valid;
    assign o_code        = r_out_code;
    assign o_code_length = r_out_len;
    assign o_status      = r_out_status;

    assign w_in_li_m1 = i_length_index - LEN_W'(1);
    assign w_li_m1    = r_li - LEN_W'(1);
    assign w_cl_m1    = r_cur_len - LEN_W'(1);
    assign w_in_li_ok = (i_length_index >= LEN_W'(1)) &&
                        (32'(i_length_index) <= MAX_CODE_LENGTH);
    assign w_cl_ok    = (r_cur_len >= LEN_W'(1)) && (32'(r_cur_len) <= MAX_CODE_LENGTH);
    assign w_sym_ok   = (32'(r_sym) < SYMBOL_SLOTS);
    // the running code must fit in the current length
    assign w_overfull = ((r_next_code >> r_cur_len) != '0);
    // total symbols expected, saturated
    assign w_total    = (r_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_W'(TOTAL_MAX) : r_sum[TOTAL_W-1:0];
    assign w_old_cnt  = r_lc_valid[w_li_m1[LC_AW-1:0]] ? r_lc_rdata : '0;
    assign w_cl_cnt   = (w_cl_ok && r_lc_valid[w_cl_m1[LC_AW-1:0]]) ? r_lc_rdata : '0;

    always_comb begin
        n_state        = r_state;
        n_cur_len      = r_cur_len;
        n_placed_len   = r_placed_len;
        n_next_code    = r_next_code;
        n_sum          = r_sum;
        n_placed_total = r_placed_total;
        n_lc_valid     = r_lc_valid;
        n_st_valid     = r_st_valid;
        n_li           = r_li;
        n_cnt          = r_cnt;
        n_sym          = r_sym;
        n_res_code     = r_res_code;
        n_res_len      = r_res_len;
        n_res_status   = r_res_status;
        n_out_code     = r_out_code;
        n_out_len      = r_out_len;
        n_out_status   = r_out_status;
        n_out_valid    = r_out_valid;

        lc_re    = 1'b0;
        lc_raddr = w_in_li_m1[LC_AW-1:0];
        lc_we    = 1'b0;
        lc_waddr = w_li_m1[LC_AW-1:0];
        st_re    = 1'b0;
        st_raddr = i_symbol[SLOT_AW-1:0];
        st_we    = 1'b0;
        st_waddr = r_sym[SLOT_AW-1:0];
        st_wdata = {r_cur_len, r_next_code[CODE_W-1:0]};

        // drop the held result once it is taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_li         = i_length_index;
                    n_cnt        = i_count;
                    n_sym        = i_symbol;
                    n_res_code   = '0;
                    n_res_len    = '0;
                    n_res_status = ST_OK;
                    case (i_mode)
                        MODE_COUNT: begin
                            if (w_in_li_ok) begin
                                lc_re   = 1'b1;
                                n_state = S_CNT;
                            end else begin
                                n_state = S_EMIT;
                            end
                        end
                        MODE_SYMBOL: begin
                            if (r_placed_total >= w_total) begin
                                n_res_status = ST_SURPLUS;
                                n_state      = S_EMIT;
                            end else begin
                                n_state = S_ADV_RD;
                            end
                        end
                        MODE_LOOKUP: begin
                            st_re   = 1'b1;
                            n_state = S_LOOK;
                        end
                        default: begin
                            // clear: back to the reset state
                            n_cur_len      = LEN_W'(1);
                            n_placed_len   = '0;
                            n_next_code    = '0;
                            n_sum          = '0;
                            n_placed_total = '0;
                            n_lc_valid     = '0;
                            n_st_valid     = '0;
                            n_state        = S_EMIT;
                        end
                    endcase
                end
            end
            S_CNT: begin
                // replace the count and patch the running total
                n_sum   = r_sum - SUM_W'(w_old_cnt) + SUM_W'(r_cnt);
                lc_we   = 1'b1;
                n_lc_valid[w_li_m1[LC_AW-1:0]] = 1'b1;
                n_state = S_EMIT;
            end
            S_LOOK: begin
                if (w_sym_ok && r_st_valid[r_sym[SLOT_AW-1:0]]) begin
                    n_res_code = r_st_rdata[CODE_W-1:0];
                    n_res_len  = r_st_rdata[ENTRY_W-1:CODE_W];
                end else begin
                    n_res_status = ST_NOT_FND;
                end
                n_state = S_EMIT;
            end
            S_ADV_RD: begin
                lc_re    = w_cl_ok;
                lc_raddr = w_cl_m1[LC_AW-1:0];
                n_state  = S_ADV_CHK;
            end
            S_ADV_CHK: begin
                if (w_cl_ok && (r_placed_len >= w_cl_cnt)) begin
                    // this length is used up: advance
                    n_placed_len = '0;
                    if (32'(r_cur_len) == MAX_CODE_LENGTH) begin
                        n_cur_len    = LEN_W'(MAX_CODE_LENGTH + 1);
                        n_res_status = ST_NO_FREE;
                        n_state      = S_EMIT;
                    end else begin
                        n_next_code = {r_next_code[NEXT_W-2:0], 1'b0};
                        n_cur_len   = r_cur_len + LEN_W'(1);
                        n_state     = S_ADV_RD;
                    end
                end else if (!w_cl_ok || w_overfull) begin
                    n_res_status = ST_NO_FREE;
                    n_state      = S_EMIT;
                end else begin
                    n_res_code = r_next_code[CODE_W-1:0];
                    n_res_len  = r_cur_len;
                    // first code for a symbol wins
                    if (w_sym_ok && !r_st_valid[r_sym[SLOT_AW-1:0]]) begin
                        st_we = 1'b1;
                        n_st_valid[r_sym[SLOT_AW-1:0]] = 1'b1;
                    end
                    n_next_code    = r_next_code + NEXT_W'(1);
                    n_placed_len   = r_placed_len + CNT_W'(1);
                    n_placed_total = r_placed_total + TOTAL_W'(1);
                    n_state        = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_code   = r_res_code;
                    n_out_len    = r_res_len;
                    n_out_status = r_res_status;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cur_len      <= LEN_W'(1);
            r_placed_len   <= '0;
            r_next_code    <= '0;
            r_sum          <= '0;
            r_placed_total <= '0;
            r_lc_valid     <= '0;
            r_st_valid     <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_cur_len      <= n_cur_len;
            r_placed_len   <= n_placed_len;
            r_next_code    <= n_next_code;
            r_sum          <= n_sum;
            r_placed_total <= n_placed_total;
            r_lc_valid     <= n_lc_valid;
            r_st_valid     <= n_st_valid;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_li         <= n_li;
        r_cnt        <= n_cnt;
        r_sym        <= n_sym;
        r_res_code   <= n_res_code;
        r_res_len    <= n_res_len;
        r_res_status <= n_res_status;
        r_out_code   <= n_out_code;
        r_out_len    <= n_out_len;
        r_out_status <= n_out_status;
    end

    // length-count memory, registered read
    always_ff @(posedge i_clk) begin
        if (lc_we) begin
            r_lc_mem[lc_waddr] <= r_cnt;
        end
        if (lc_re) begin
            r_lc_rdata <= r_lc_mem[lc_raddr];
        end
    end

    // code store memory, registered read
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_st_mem[st_waddr] <= st_wdata;
        end
        if (st_re) begin
            r_st_rdata <= r_st_mem[st_raddr];
        end
    end

    // a check step always follows its memory read
    a_chk_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADV_CHK) |-> ($past(r_state) == S_ADV_RD))
        else $error("length check without a preceding count read");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_len >= LEN_W'(1)) && (32'(r_cur_len) <= MAX_CODE_LENGTH + 1))
        else $error("current length out of range");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> ((o_code == '0) && (o_code_length == '0)))
        else $error("error result carries a code");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_mode == MODE_CLEAR)) |=>
        ((r_sum == '0) && (r_cur_len == LEN_W'(1)) && (r_st_valid == '0)))
        else $error("clear did not empty the table");

    a_emit_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && r_out_valid && i_out_stall) |=> (r_state == S_EMIT))
        else $error("pending result left while output was blocked");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for canonical_huffman_code_table: a queued request driver,
// a result monitor and a table model. Depends on chc_pkg and the block's RTL only.
module tb_top;
    import chc_pkg::*;

    localparam int MAX_LEN         = DEF_MAX_CODE_LENGTH;
    localparam int SLOTS           = DEF_SYMBOL_SLOTS;
    localparam int TARGET_REQUESTS = 1500;
    localparam int CYCLE_LIMIT     = 400000;
    // The slowest request passes every length.
    localparam int DRAIN_CYCLES    = 48;
    localparam int IDLE_PERCENT    = 16;
    // Window with no idling on either side.
    localparam int STEADY_FROM     = 3000;
    localparam int STEADY_TO       = 5500;
    // Long receiver hold-off so that the block backs up into its input.
    localparam int HOLD_OFF_AT     = 1500;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct packed {
        t_mode   mode;
        t_len    length_index;
        t_count  count;
        t_symbol symbol;
    } t_huff_req;

    typedef struct packed {
        t_code   code;
        t_len    code_len;
        t_status status;
    } t_huff_result;

    // Clock, reset and the block's inputs, all known from time zero.
    logic     i_clk          = 1'b0;
    logic     i_rst_n        = 1'b0;
    logic     i_in_valid     = 1'b0;
    t_mode    i_mode         = MODE_COUNT;
    t_len     i_length_index = '0;
    t_count   i_count        = '0;
    t_symbol  i_symbol       = '0;
    logic     i_out_stall    = 1'b0;

    logic     o_in_stall;
    logic     o_out_valid;
    t_code    o_code;
    t_len     o_code_length;
    t_status  o_status;

    // Request backlog and the codes we expect back, oldest first.
    t_huff_req    request_backlog[$];
    t_huff_result expected_codes[$];

    int unsigned cycle_count       = 0;
    int unsigned hold_off_left     = 0;
    int unsigned requests_queued   = 0;
    int unsigned requests_accepted = 0;
    int unsigned results_checked   = 0;
    int unsigned mismatches        = 0;
    int unsigned tables_built      = 0;
    int unsigned status_tally[4];

    // Model of the table engine.
    logic [CNT_W-1:0]   len_counts[1:MAX_LEN];
    logic               slot_valid[SLOTS];
    t_len               slot_len[SLOTS];
    t_code              slot_code[SLOTS];
    logic [LEN_W-1:0]   cur_length;
    logic [CNT_W-1:0]   placed_at_len;
    logic [NEXT_W-1:0]  next_code;
    logic [TOTAL_W-1:0] symbol_total;
    logic [TOTAL_W-1:0] symbols_placed;

    wire steady_window = cycle_count >= STEADY_FROM && cycle_count < STEADY_TO;

    canonical_huffman_code_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_length_index (i_length_index),
        .i_count        (i_count),
        .i_symbol       (i_symbol),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_code         (o_code),
        .o_code_length  (o_code_length),
        .o_status       (o_status)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------
    function automatic void clear_table_model();
        foreach (len_counts[l]) len_counts[l] = '0;
        foreach (slot_valid[s]) begin
            slot_valid[s] = 1'b0;
            slot_len[s]   = '0;
            slot_code[s]  = '0;
        end
        cur_length     = LEN_W'(1);
        placed_at_len  = '0;
        next_code      = '0;
        symbol_total   = '0;
        symbols_placed = '0;
    endfunction

    // Apply one request to the model and return the result it must produce.
    function automatic t_huff_result predict_code_result(t_huff_req req);
        t_huff_result res;
        int unsigned  sum;
        res = '{code: '0, code_len: '0, status: ST_OK};
        case (req.mode)
            MODE_COUNT: begin
                // Out-of-range lengths leave the table untouched.
                if (req.length_index >= 1 && req.length_index <= MAX_LEN) begin
                    len_counts[req.length_index] = req.count;
                    sum = 0;
                    foreach (len_counts[l]) sum += len_counts[l];
                    symbol_total = (sum > TOTAL_MAX) ? TOTAL_MAX[TOTAL_W-1:0]
                                                     : sum[TOTAL_W-1:0];
                end
            end
            MODE_SYMBOL: begin
                if (symbols_placed >= symbol_total) begin
                    res.status = ST_SURPLUS;
                end else begin
                    // Skip lengths whose codes are all placed, doubling the
                    // running code per length passed.
                    while (cur_length >= 1 && cur_length <= MAX_LEN &&
                           placed_at_len >= len_counts[cur_length]) begin
                        if (cur_length == MAX_LEN) begin
                            cur_length    = LEN_W'(MAX_LEN + 1);
                            placed_at_len = '0;
                            break;
                        end
                        next_code     = next_code << 1;
                        cur_length    = cur_length + LEN_W'(1);
                        placed_at_len = '0;
                    end
                    if (cur_length < 1 || cur_length > MAX_LEN ||
                        int'(next_code) >= (1 << cur_length)) begin
                        res.status = ST_NO_FREE;
                    end else begin
                        res.code     = next_code[CODE_W-1:0];
                        res.code_len = cur_length;
                        // A repeated symbol keeps the code it got first.
                        if (!slot_valid[req.symbol]) begin
                            slot_valid[req.symbol] = 1'b1;
                            slot_len[req.symbol]   = cur_length;
                            slot_code[req.symbol]  = next_code[CODE_W-1:0];
                        end
                        next_code      = next_code + NEXT_W'(1);
                        placed_at_len  = placed_at_len + CNT_W'(1);
                        symbols_placed = symbols_placed + TOTAL_W'(1);
                    end
                end
            end
            MODE_LOOKUP: begin
                if (slot_valid[req.symbol]) begin
                    res.code     = slot_code[req.symbol];
                    res.code_len = slot_len[req.symbol];
                end else begin
                    res.status = ST_NOT_FND;
                end
            end
            default: clear_table_model();
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic queue_request(t_mode mode, int li, int cnt, int sym);
        t_huff_req req;
        req.mode         = mode;
        req.length_index = li[LEN_W-1:0];
        req.count        = cnt[CNT_W-1:0];
        req.symbol       = sym[SYM_W-1:0];
        request_backlog.push_back(req);
        requests_queued++;
    endtask

    // Any request at all, full field ranges, including clears.
    task automatic queue_noise();
        queue_request(t_mode'($urandom_range(3)), $urandom_range(31),
                      $urandom_range(255), $urandom_range(255));
    endtask

    // One table: clear, load counts, place symbols, look some up.
    // Mostly a well-formed prefix tree; sometimes overfull or built on top of
    // the previous table's state.
    task automatic queue_random_table();
        int   cnt[1:MAX_LEN];
        int   lengths[$];
        int   placed_syms[$];
        int   max_len, avail, total, pick, sym, r, l;
        bit   keep_zeros;
        max_len = ($urandom_range(3) == 0) ? $urandom_range(MAX_LEN, 9)
                                           : $urandom_range(8, 1);
        avail = 2;
        total = 0;
        for (l = 1; l <= MAX_LEN; l++) begin
            cnt[l] = 0;
            if (l < max_len) begin
                // Keep at least one leaf free so the tree reaches max_len.
                r = $urandom_range(3);
                if (r == 0)
                    cnt[l] = 0;
                else if (r == 1 || avail - 1 > 3)
                    cnt[l] = $urandom_range((avail - 1 > 3) ? 3 : avail - 1);
                else
                    cnt[l] = avail - 1;
                avail = (avail - cnt[l]) * 2;
                if (avail > 4096) avail = 4096;
            end else if (l == max_len) begin
                // Sometimes fill the last length so the all-ones code shows up.
                if (avail <= 12 && $urandom_range(1))
                    cnt[l] = avail;
                else
                    cnt[l] = (avail < 6) ? $urandom_range(avail, 1) : $urandom_range(6, 1);
            end
            total += cnt[l];
        end
        // Overfull tree now and then.
        if ($urandom_range(9) == 0) begin
            l = $urandom_range(max_len, 1);
            cnt[l] = cnt[l] + 1;
            total++;
        end

        if ($urandom_range(5) != 0) queue_request(MODE_CLEAR, 0, 0, 0);
        keep_zeros = ($urandom_range(2) == 0);
        for (l = 1; l <= MAX_LEN; l++)
            if (cnt[l] != 0 || keep_zeros) lengths.push_back(l);
        // Load the counts in random order.
        while (lengths.size() != 0) begin
            pick = $urandom_range(lengths.size() - 1);
            queue_request(MODE_COUNT, lengths[pick], cnt[lengths[pick]], $urandom_range(255));
            lengths.delete(pick);
            if ($urandom_range(99) < 8) queue_noise();
        end

        // Symbols, with a duplicate now and then and sometimes a surplus at the end.
        for (int i = 0; i < total; i++) begin
            if (placed_syms.size() != 0 && $urandom_range(15) == 0)
                sym = placed_syms[$urandom_range(placed_syms.size() - 1)];
            else
                sym = $urandom_range(255);
            placed_syms.push_back(sym);
            queue_request(MODE_SYMBOL, $urandom_range(31), $urandom_range(255), sym);
            if ($urandom_range(99) < 6) queue_noise();
            if ($urandom_range(99) < 10)
                queue_request(MODE_LOOKUP, 0, 0, placed_syms[$urandom_range(i)]);
        end
        if ($urandom_range(3) == 0)
            queue_request(MODE_SYMBOL, 0, 0, $urandom_range(255));

        // Lookups: mostly placed symbols, some arbitrary values.
        r = $urandom_range(6, 1);
        for (int i = 0; i < r; i++) begin
            if (placed_syms.size() != 0 && $urandom_range(3) != 0)
                sym = placed_syms[$urandom_range(placed_syms.size() - 1)];
            else
                sym = $urandom_range(255);
            queue_request(MODE_LOOKUP, $urandom_range(31), $urandom_range(255), sym);
        end
        tables_built++;
    endtask

    // ------------------------------------------------------------------
    // Request driver: hold a stalled request, otherwise advance or idle.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_requests
        t_huff_req cur_req;
        t_huff_req next_req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            clear_table_model();
        end else begin
            if (i_in_valid && !o_in_stall) begin
                cur_req.mode         = i_mode;
                cur_req.length_index = i_length_index;
                cur_req.count        = i_count;
                cur_req.symbol       = i_symbol;
                expected_codes.push_back(predict_code_result(cur_req));
                requests_accepted++;
            end
            // Only a request that was taken (or none at all) may be replaced.
            if (!i_in_valid || !o_in_stall) begin
                if (request_backlog.size() != 0 &&
                    (steady_window || $urandom_range(99) >= IDLE_PERCENT)) begin
                    next_req = request_backlog.pop_front();
                    i_in_valid     <= 1'b1;
                    i_mode         <= next_req.mode;
                    i_length_index <= next_req.length_index;
                    i_count        <= next_req.count;
                    i_symbol       <= next_req.symbol;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off on the result side, counted here on its own.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            hold_off_left <= 0;
        else if (cycle_count == HOLD_OFF_AT)
            hold_off_left <= HOLD_OFF_CYCLES;
        else if (hold_off_left != 0)
            hold_off_left <= hold_off_left - 1;
    end

    // Result-side stall: random, plus the hold-off, none in the steady window.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= (hold_off_left != 0) ||
                           (!steady_window && $urandom_range(99) < IDLE_PERCENT);
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each accepted result with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_huff_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_checked++;
            status_tally[o_status]++;
            if (expected_codes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result with no request pending: code %h len %0d status %0d",
                             $realtime, o_code, o_code_length, o_status);
            end else begin
                want = expected_codes.pop_front();
                if (o_code !== want.code || o_code_length !== want.code_len ||
                    o_status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("[%0t] result %0d: expected code %h len %0d status %0d",
                                 $realtime, results_checked, want.code, want.code_len,
                                 want.status);
                        $display("    got code %h len %0d status %0d",
                                 o_code, o_code_length, o_status);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, expected_codes.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        // Directed: empty table, ignored lengths, a small tree with a
        // duplicate and a surplus, an earlier length reloaded after passing
        // it, a clear, and saturated counts with an overfull first length.
        queue_request(MODE_LOOKUP, 0, 0, 0);
        queue_request(MODE_SYMBOL, 0, 0, 8'h12);
        queue_request(MODE_COUNT, 0, 5, 0);
        queue_request(MODE_COUNT, 17, 255, 0);
        queue_request(MODE_COUNT, 31, 8'hAA, 8'hFF);
        queue_request(MODE_COUNT, 1, 1, 0);
        queue_request(MODE_COUNT, 2, 1, 0);
        queue_request(MODE_COUNT, 3, 2, 0);
        queue_request(MODE_SYMBOL, 0, 0, 255);
        queue_request(MODE_SYMBOL, 0, 0, 0);
        queue_request(MODE_SYMBOL, 0, 0, 0);
        queue_request(MODE_SYMBOL, 0, 0, 85);
        queue_request(MODE_SYMBOL, 0, 0, 9);
        queue_request(MODE_LOOKUP, 0, 0, 0);
        queue_request(MODE_LOOKUP, 0, 0, 255);
        queue_request(MODE_LOOKUP, 0, 0, 170);
        queue_request(MODE_COUNT, 1, 2, 0);
        queue_request(MODE_SYMBOL, 0, 0, 7);
        queue_request(MODE_CLEAR, 0, 0, 0);
        queue_request(MODE_LOOKUP, 0, 0, 255);
        queue_request(MODE_COUNT, 1, 255, 0);
        queue_request(MODE_COUNT, 16, 255, 0);
        queue_request(MODE_COUNT, 8, 255, 0);
        queue_request(MODE_SYMBOL, 0, 0, 1);
        queue_request(MODE_SYMBOL, 0, 0, 2);
        queue_request(MODE_SYMBOL, 0, 0, 3);
        queue_request(MODE_CLEAR, 0, 0, 0);

        // Random tables with some noise in between.
        while (requests_queued < TARGET_REQUESTS) begin
            if ($urandom_range(9) == 0) queue_noise();
            queue_random_table();
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every request is taken, then until every result is in.
        while (requests_accepted < requests_queued) @(posedge i_clk);
        while (expected_codes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_codes.size() != 0) mismatches++;

        $display("Covered %0d requests over %0d tables in %0d cycles, %0d results checked",
                 requests_accepted, tables_built, cycle_count, results_checked);
        $display("Statuses seen: ok %0d, no free code %0d, not found %0d, surplus %0d",
                 status_tally[ST_OK], status_tally[ST_NO_FREE],
                 status_tally[ST_NOT_FND], status_tally[ST_SURPLUS]);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
